// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside of reset.
`define KF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/kfcv_pkg.sv
package kfcv_pkg;

  // Q16.16 in 32 bits
  localparam int DW = 32;
  localparam int FB = 16;

  typedef logic signed [DW-1:0] data_t;

  localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};

  // Request codes
  typedef enum logic [1:0] {
    REQ_INIT = 2'd0,
    REQ_PRED = 2'd1,
    REQ_UPD  = 2'd2
  } req_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_MNXX = 3'd0;
  localparam logic [2:0] CFG_MNXY = 3'd1;
  localparam logic [2:0] CFG_MNYY = 3'd2;
  localparam logic [2:0] CFG_ACCX = 3'd3;
  localparam logic [2:0] CFG_ACCY = 3'd4;
  localparam logic [2:0] CFG_IVP  = 3'd5;
  localparam logic [2:0] CFG_IVV  = 3'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [30:0]        dt;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } kf_in_t;

  typedef struct packed {
    logic signed [31:0] est_pos_x;
    logic signed [31:0] est_pos_y;
    logic signed [31:0] est_vel_x;
    logic signed [31:0] est_vel_y;
    logic               singular;
    logic               saturated;
  } kf_out_t;

  // Micro-operations of the shared unit
  typedef enum logic [3:0] {
    OP_MOV  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_SHR1 = 4'd5,
    OP_SHR2 = 4'd6,
    OP_BZ   = 4'd7,
    OP_END  = 4'd8
  } op_e;

  typedef logic [6:0] addr_t;

  typedef struct packed {
    op_e   op;
    addr_t dst;
    addr_t a;
    addr_t b;
  } instr_t;

  // Operand space: bit 6 clear is the scratch memory, set is a fixed source
  localparam int MEM_DEPTH = 64;
  localparam int A_ST   = 0;
  localparam int A_COV  = 4;
  localparam int A_T1   = 20;
  localparam int A_T2   = 21;
  localparam int A_T3   = 22;
  localparam int A_Y0   = 23;
  localparam int A_Y1   = 24;
  localparam int A_S00  = 25;
  localparam int A_S01  = 26;
  localparam int A_S10  = 27;
  localparam int A_S11  = 28;
  localparam int A_DET  = 29;
  localparam int A_SI   = 30;
  localparam int A_K    = 34;
  localparam int A_NP   = 42;
  localparam int A_DT2  = 50;
  localparam int A_DT3  = 51;
  localparam int A_DT4  = 52;
  localparam int A_D44  = 53;
  localparam int A_D32  = 54;
  localparam int A_ZERO = 64;
  localparam int A_DT   = 65;
  localparam int A_PX   = 66;
  localparam int A_PY   = 67;
  localparam int A_VX   = 68;
  localparam int A_VY   = 69;
  localparam int A_R0   = 70;
  localparam int A_RXY  = 71;
  localparam int A_R2   = 72;
  localparam int A_AX   = 73;
  localparam int A_AY   = 74;
  localparam int A_IVP  = 75;
  localparam int A_IVV  = 76;

  // Program entry points
  localparam int PROG_DEPTH = 256;
  localparam logic [7:0] PC_INIT = 8'd0;
  localparam logic [7:0] PC_PRED = 8'd24;
  localparam logic [7:0] PC_UPD  = 8'd96;
  localparam logic [7:0] PC_NOP  = 8'd255;

  typedef instr_t [PROG_DEPTH-1:0] prog_t;

  // Divider handshake
  typedef struct packed {
    logic  start;
    data_t a;
    data_t b;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t q;
    logic  sat;
  } div_rsp_t;

  function automatic instr_t mk(op_e op, int dst, int a, int b);
    instr_t r;
    r.op  = op;
    r.dst = addr_t'(dst);
    r.a   = addr_t'(a);
    r.b   = addr_t'(b);
    return r;
  endfunction

  // Microcode for init, predict and update
  function automatic prog_t build_prog();
    prog_t p;
    int n;
    int i;
    int j;
    int k;
    int src;
    int dst;
    int nz;
    int bs;
    for (i = 0; i < PROG_DEPTH; i++) p[i] = mk(OP_END, 0, 0, 0);

    // init: load state, diagonal covariance
    n = int'(PC_INIT);
    for (i = 0; i < 4; i++) begin
      p[n] = mk(OP_MOV, A_ST + i, A_PX + i, A_ZERO); n = n + 1;
    end
    for (i = 0; i < 16; i++) begin
      if (i == 0 || i == 5) src = A_IVP;
      else if (i == 10 || i == 15) src = A_IVV;
      else src = A_ZERO;
      p[n] = mk(OP_MOV, A_COV + i, src, A_ZERO); n = n + 1;
    end

    // predict: x = F x
    n = int'(PC_PRED);
    for (i = 0; i < 2; i++) begin
      p[n] = mk(OP_MUL, A_T1, A_DT, A_ST + 2 + i); n = n + 1;
      p[n] = mk(OP_ADD, A_ST + i, A_ST + i, A_T1); n = n + 1;
    end
    // F P
    for (i = 0; i < 4; i++) begin
      p[n] = mk(OP_MUL, A_T1, A_DT, A_COV + 8 + i); n = n + 1;
      p[n] = mk(OP_ADD, A_COV + i, A_COV + i, A_T1); n = n + 1;
      p[n] = mk(OP_MUL, A_T1, A_DT, A_COV + 12 + i); n = n + 1;
      p[n] = mk(OP_ADD, A_COV + 4 + i, A_COV + 4 + i, A_T1); n = n + 1;
    end
    // (F P) F'
    for (i = 0; i < 4; i++) begin
      p[n] = mk(OP_MUL, A_T1, A_COV + i*4 + 2, A_DT); n = n + 1;
      p[n] = mk(OP_ADD, A_COV + i*4, A_COV + i*4, A_T1); n = n + 1;
      p[n] = mk(OP_MUL, A_T1, A_COV + i*4 + 3, A_DT); n = n + 1;
      p[n] = mk(OP_ADD, A_COV + i*4 + 1, A_COV + i*4 + 1, A_T1); n = n + 1;
    end
    // powers of dt
    p[n] = mk(OP_MUL, A_DT2, A_DT, A_DT); n = n + 1;
    p[n] = mk(OP_MUL, A_DT3, A_DT2, A_DT); n = n + 1;
    p[n] = mk(OP_MUL, A_DT4, A_DT3, A_DT); n = n + 1;
    p[n] = mk(OP_SHR2, A_D44, A_DT4, A_ZERO); n = n + 1;
    p[n] = mk(OP_SHR1, A_D32, A_DT3, A_ZERO); n = n + 1;
    // + Q, one axis at a time
    for (k = 0; k < 2; k++) begin
      nz = (k == 0) ? A_AX : A_AY;
      bs = A_COV + ((k == 0) ? 0 : 5);
      p[n] = mk(OP_MUL, A_T1, nz, A_D44); n = n + 1;
      p[n] = mk(OP_ADD, bs, bs, A_T1); n = n + 1;
      p[n] = mk(OP_MUL, A_T1, nz, A_D32); n = n + 1;
      p[n] = mk(OP_ADD, bs + 2, bs + 2, A_T1); n = n + 1;
      p[n] = mk(OP_MUL, A_T1, nz, A_D32); n = n + 1;
      p[n] = mk(OP_ADD, bs + 8, bs + 8, A_T1); n = n + 1;
      p[n] = mk(OP_MUL, A_T1, nz, A_DT2); n = n + 1;
      p[n] = mk(OP_ADD, bs + 10, bs + 10, A_T1); n = n + 1;
    end

    // update: innovation and S
    n = int'(PC_UPD);
    p[n] = mk(OP_SUB, A_Y0, A_PX, A_ST); n = n + 1;
    p[n] = mk(OP_SUB, A_Y1, A_PY, A_ST + 1); n = n + 1;
    p[n] = mk(OP_ADD, A_S00, A_COV, A_R0); n = n + 1;
    p[n] = mk(OP_ADD, A_S01, A_COV + 1, A_RXY); n = n + 1;
    p[n] = mk(OP_ADD, A_S10, A_COV + 4, A_RXY); n = n + 1;
    p[n] = mk(OP_ADD, A_S11, A_COV + 5, A_R2); n = n + 1;
    p[n] = mk(OP_MUL, A_T1, A_S00, A_S11); n = n + 1;
    p[n] = mk(OP_MUL, A_T2, A_S01, A_S10); n = n + 1;
    p[n] = mk(OP_SUB, A_DET, A_T1, A_T2); n = n + 1;
    p[n] = mk(OP_BZ, 0, A_DET, A_ZERO); n = n + 1;
    // inverse of S
    p[n] = mk(OP_DIV, A_SI, A_S11, A_DET); n = n + 1;
    p[n] = mk(OP_SUB, A_T1, A_ZERO, A_S01); n = n + 1;
    p[n] = mk(OP_DIV, A_SI + 1, A_T1, A_DET); n = n + 1;
    p[n] = mk(OP_SUB, A_T1, A_ZERO, A_S10); n = n + 1;
    p[n] = mk(OP_DIV, A_SI + 2, A_T1, A_DET); n = n + 1;
    p[n] = mk(OP_DIV, A_SI + 3, A_S00, A_DET); n = n + 1;
    // gain K = P H' S^-1
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 2; j++) begin
        p[n] = mk(OP_MUL, A_T1, A_COV + i*4, A_SI + j); n = n + 1;
        p[n] = mk(OP_MUL, A_T2, A_COV + i*4 + 1, A_SI + 2 + j); n = n + 1;
        p[n] = mk(OP_ADD, A_K + i*2 + j, A_T1, A_T2); n = n + 1;
      end
    end
    // state correction
    for (i = 0; i < 4; i++) begin
      p[n] = mk(OP_MUL, A_T1, A_K + i*2, A_Y0); n = n + 1;
      p[n] = mk(OP_MUL, A_T2, A_K + i*2 + 1, A_Y1); n = n + 1;
      p[n] = mk(OP_ADD, A_T3, A_T1, A_T2); n = n + 1;
      p[n] = mk(OP_ADD, A_ST + i, A_ST + i, A_T3); n = n + 1;
    end
    // covariance: rows 2,3 in place, rows 0,1 staged since later rows read them
    for (k = 0; k < 4; k++) begin
      i = (k + 2) % 4;
      for (j = 0; j < 4; j++) begin
        dst = (i >= 2) ? (A_COV + i*4 + j) : (A_NP + i*4 + j);
        p[n] = mk(OP_MUL, A_T1, A_K + i*2, A_COV + j); n = n + 1;
        p[n] = mk(OP_MUL, A_T2, A_K + i*2 + 1, A_COV + 4 + j); n = n + 1;
        p[n] = mk(OP_ADD, A_T3, A_T1, A_T2); n = n + 1;
        p[n] = mk(OP_SUB, dst, A_COV + i*4 + j, A_T3); n = n + 1;
      end
    end
    for (i = 0; i < 8; i++) begin
      p[n] = mk(OP_MOV, A_COV + i, A_NP + i, A_ZERO); n = n + 1;
    end
    return p;
  endfunction

  localparam prog_t PROG = build_prog();

endpackage

// File: hw/rtl/kfcv_alu.sv
module kfcv_alu import kfcv_pkg::*; (
  input  op_e   op_i,
  input  data_t a_i,
  input  data_t b_i,
  output data_t res_o,
  output logic  sat_o
);

  localparam int PW = 2 * DW;
  localparam int SW = PW - FB;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] prod_s;
  logic signed [DW:0]   sum;
  logic signed [DW:0]   dif;
  logic                 prod_fit;

  // full product, round half up at the binary point
  always_comb begin
    prod     = PW'(a_i) * PW'(b_i);
    prod_r   = prod + (PW'(1) <<< (FB - 1));
    prod_s   = prod_r[PW-1:FB];
    prod_fit = (&prod_s[SW-1:DW-1]) | ~(|prod_s[SW-1:DW-1]);
    sum      = (DW+1)'(a_i) + (DW+1)'(b_i);
    dif      = (DW+1)'(a_i) - (DW+1)'(b_i);
  end

  // result select with clamping
  always_comb begin
    res_o = a_i;
    sat_o = 1'b0;
    case (op_i)
      OP_ADD: begin
        if (sum[DW] != sum[DW-1]) begin
          sat_o = 1'b1;
          res_o = sum[DW] ? DMIN : DMAX;
        end else begin
          res_o = sum[DW-1:0];
        end
      end
      OP_SUB: begin
        if (dif[DW] != dif[DW-1]) begin
          sat_o = 1'b1;
          res_o = dif[DW] ? DMIN : DMAX;
        end else begin
          res_o = dif[DW-1:0];
        end
      end
      OP_MUL: begin
        if (!prod_fit) begin
          sat_o = 1'b1;
          res_o = prod_s[SW-1] ? DMIN : DMAX;
        end else begin
          res_o = prod_s[DW-1:0];
        end
      end
      OP_SHR1: res_o = a_i >>> 1;
      OP_SHR2: res_o = a_i >>> 2;
      default: res_o = a_i;
    endcase
  end

endmodule

// File: hw/rtl/kfcv_div.sv
module kfcv_div import kfcv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int NW = DW + FB;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM_P = NW'(DMAX);
  localparam logic [NW-1:0] LIM_N = LIM_P + NW'(1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic          neg_q;

  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   rem_d;
  logic [NW-1:0] qneg;
  logic          big;

  // restoring step, one quotient bit per cycle
  always_comb begin
    mag_a = req_i.a[DW-1] ? DW'(-req_i.a) : DW'(req_i.a);
    mag_b = req_i.b[DW-1] ? DW'(-req_i.b) : DW'(req_i.b);
    trial = {rem_q, quo_q[NW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? (trial - {1'b0, den_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= {mag_a, FB'(0)};
      den_q <= mag_b;
      neg_q <= req_i.a[DW-1] ^ req_i.b[DW-1];
    end else if (busy_q) begin
      rem_q <= rem_d[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  // sign and clamp of the quotient
  always_comb begin
    qneg      = -quo_q;
    big       = neg_q ? (quo_q > LIM_N) : (quo_q > LIM_P);
    rsp_o.done = done_q;
    rsp_o.sat  = big;
    if (big) rsp_o.q = neg_q ? DMIN : DMAX;
    else     rsp_o.q = neg_q ? qneg[DW-1:0] : quo_q[DW-1:0];
  end

endmodule

// File: hw/rtl/kalman_filter_const_velocity_2d.sv
// Four-state constant-velocity Kalman filter (x, y position and velocity) in
// saturating signed Q16.16. Each transaction is one request: init, predict or
// position update, and returns the new state with singular/saturated flags.
// A microcoded sequencer drives one shared multiply/add unit and a radix-2
// divider over a 64-word scratch memory. Every micro-op has an operand read
// step and an execute step; a divide also waits for the divider. An update
// runs four divides; singular updates stop after the determinant. The input
// is not ready while a request runs; a finished result waits in the output
// register.
`include "assert_macros.svh"

module kalman_filter_const_velocity_2d import kfcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  kf_in_t     in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output kf_out_t    out_data_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EX   = 5'b00100,
    S_DIVW = 5'b01000,
    S_DONE = 5'b10000
  } st_e;

  st_e    state_q, state_d;
  logic [7:0] pc_q, pc_d;
  instr_t instr_q;
  data_t  opa_q, opb_q;
  logic   sat_q;
  logic   sing_q;
  kf_in_t in_q;
  data_t  st_q [4];
  logic   out_valid_q;
  kf_out_t out_q;

  logic [30:0] mnxx_q, mnyy_q, accx_q, accy_q, ivp_q, ivv_q;
  logic [31:0] mnxy_q;

  logic [DW-1:0] mem_q [MEM_DEPTH];
  logic          valid_q [MEM_DEPTH];

  instr_t   fetch;
  data_t    alu_res;
  logic     alu_sat;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     we;
  data_t    wdata;
  logic     wsat;
  logic     in_acc;
  logic     out_load;

  assign fetch      = PROG[pc_q];
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // operand fetch: scratch memory or a fixed source
  function automatic data_t rd_src(addr_t ad, kf_in_t iq, logic [30:0] r0, logic [31:0] rxy,
                                   logic [30:0] r2, logic [30:0] ax, logic [30:0] ay,
                                   logic [30:0] ivp, logic [30:0] ivv);
    data_t v;
    case (int'(ad))
      A_DT:    v = DW'(iq.dt);
      A_PX:    v = iq.pos_x;
      A_PY:    v = iq.pos_y;
      A_VX:    v = iq.vel_x;
      A_VY:    v = iq.vel_y;
      A_R0:    v = DW'(r0);
      A_RXY:   v = rxy;
      A_R2:    v = DW'(r2);
      A_AX:    v = DW'(ax);
      A_AY:    v = DW'(ay);
      A_IVP:   v = DW'(ivp);
      A_IVV:   v = DW'(ivv);
      default: v = '0;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      instr_q <= fetch;
      if (fetch.a[6]) opa_q <= rd_src(fetch.a, in_q, mnxx_q, mnxy_q, mnyy_q, accx_q, accy_q,
                                      ivp_q, ivv_q);
      else opa_q <= valid_q[fetch.a[5:0]] ? mem_q[fetch.a[5:0]] : '0;
      if (fetch.b[6]) opb_q <= rd_src(fetch.b, in_q, mnxx_q, mnxy_q, mnyy_q, accx_q, accy_q,
                                      ivp_q, ivv_q);
      else opb_q <= valid_q[fetch.b[5:0]] ? mem_q[fetch.b[5:0]] : '0;
    end
  end

  kfcv_alu u_alu (
    .op_i  (instr_q.op),
    .a_i   (opa_q),
    .b_i   (opb_q),
    .res_o (alu_res),
    .sat_o (alu_sat)
  );

  assign div_req.start = (state_q == S_EX) && (instr_q.op == OP_DIV);
  assign div_req.a     = opa_q;
  assign div_req.b     = opb_q;

  kfcv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // write-back select
  always_comb begin
    we    = 1'b0;
    wdata = alu_res;
    wsat  = alu_sat;
    if (state_q == S_DIVW) begin
      we    = div_rsp.done;
      wdata = div_rsp.q;
      wsat  = div_rsp.sat;
    end else if (state_q == S_EX) begin
      we = (instr_q.op != OP_DIV) && (instr_q.op != OP_BZ) && (instr_q.op != OP_END);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[instr_q.dst[5:0]] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEM_DEPTH; i++) valid_q[i] <= 1'b0;
      for (int i = 0; i < 4; i++) st_q[i] <= '0;
    end else if (we) begin
      valid_q[instr_q.dst[5:0]] <= 1'b1;
      if (instr_q.dst[5:2] == 4'd0) st_q[instr_q.dst[1:0]] <= wdata;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RD;
          case (req_e'(in_data_i.req_type))
            REQ_INIT: pc_d = PC_INIT;
            REQ_PRED: pc_d = PC_PRED;
            REQ_UPD:  pc_d = PC_UPD;
            default:  pc_d = PC_NOP;
          endcase
        end
      end
      S_RD: begin
        state_d = (fetch.op == OP_END) ? S_DONE : S_EX;
      end
      S_EX: begin
        if (instr_q.op == OP_DIV) begin
          state_d = S_DIVW;
        end else if (instr_q.op == OP_BZ && opa_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RD;
          pc_d    = pc_q + 8'd1;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          state_d = S_RD;
          pc_d    = pc_q + 8'd1;
        end
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      sat_q   <= 1'b0;
      sing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (in_acc) begin
        sat_q  <= 1'b0;
        sing_q <= 1'b0;
      end else begin
        if (we && wsat) sat_q <= 1'b1;
        if (state_q == S_EX && instr_q.op == OP_BZ && opa_q == '0) sing_q <= 1'b1;
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.est_pos_x <= st_q[0];
      out_q.est_pos_y <= st_q[1];
      out_q.est_vel_x <= st_q[2];
      out_q.est_vel_y <= st_q[3];
      out_q.singular  <= sing_q;
      out_q.saturated <= sat_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mnxx_q <= 31'd1475;
      mnxy_q <= 32'd0;
      mnyy_q <= 31'd1475;
      accx_q <= 31'd589824;
      accy_q <= 31'd589824;
      ivp_q  <= 31'd65536;
      ivv_q  <= 31'd65536000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MNXX: mnxx_q <= cfg_wdata_i[30:0];
        CFG_MNXY: mnxy_q <= cfg_wdata_i;
        CFG_MNYY: mnyy_q <= cfg_wdata_i[30:0];
        CFG_ACCX: accx_q <= cfg_wdata_i[30:0];
        CFG_ACCY: accy_q <= cfg_wdata_i[30:0];
        CFG_IVP:  ivp_q  <= cfg_wdata_i[30:0];
        CFG_IVV:  ivv_q  <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // checks
  `KF_ASSERT_IMP(a_divw_op, state_q == S_DIVW, instr_q.op == OP_DIV, "divide wait without divide")
  `KF_ASSERT_NXT(a_acc_start, in_acc, state_q == S_RD && !sat_q && !sing_q, "request start bad")
  `KF_ASSERT_IMP(a_sing_bz, state_q == S_DONE && sing_q, instr_q.op == OP_BZ, "singular not from test")

endmodule
